@@ hw/rtl/adckd_pkg.sv @@
`default_nettype none
package adckd_pkg;

  localparam int KEY_SLOTS = 16;
  localparam int ADC_BITS  = 10;
  localparam int SLOT_W    = $clog2(KEY_SLOTS);
  localparam int LINE_W    = 4;
  localparam int CODE_W    = 8;

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [3:0]          key_slot;
    logic [LINE_W-1:0]   line_id;
    logic [ADC_BITS-1:0] ad_value;
    logic [ADC_BITS-1:0] half_width;
    logic [CODE_W-1:0]   key_code;
    logic                entry_valid;
  } req_t;

  typedef struct packed {
    logic [CODE_W-1:0] found_code;
    logic [3:0]        found_slot;
    logic              found;
    logic              last;
  } rsp_t;

  // one table entry as kept in the key memory
  typedef struct packed {
    logic [LINE_W-1:0]   line;
    logic [ADC_BITS-1:0] nominal;
    logic [ADC_BITS-1:0] tolerance;
    logic [CODE_W-1:0]   code;
  } key_entry_t;

endpackage
`default_nettype wire

@@ hw/rtl/adc_ladder_key_decoder_core.sv @@
`default_nettype none
// channel   | ports                          | handshake
// ----------+--------------------------------+--------------------------------------
// request   | start, busy, request (req_t)   | taken at edge with start & !busy
// result    | result_strobe, result (rsp_t)  | valid for one cycle while strobe high
//
// A write request goes to the key memory at the accepting edge; busy stays low.
// A lookup walks every slot: S_J_REQ per empty slot, S_J_REQ and S_J_LOAD per valid
// slot on another line, and per valid slot on the line S_J_REQ, S_J_LOAD (entry read),
// S_K_SCAN (scan of all slots through the single memory read port) and S_TEST (window
// test), then S_DONE for the last result. Results leave one hit behind the scan.
// Reset clears the valid bits and the sequencer; the receiver cannot stall.
module adc_ladder_key_decoder_core
  import adckd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  req_t      request,
  output logic      result_strobe,
  output rsp_t      result
);

  localparam int KC_W = $clog2(KEY_SLOTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_J_REQ,
    S_J_LOAD,
    S_K_SCAN,
    S_TEST,
    S_DONE
  } state_t;

  state_t state;

  key_entry_t mem [KEY_SLOTS];
  key_entry_t rd_data;
  logic [SLOT_W-1:0] rd_addr;
  logic [KEY_SLOTS-1:0] key_valid;

  logic accept, wr_en;
  key_entry_t wr_entry;

  logic [LINE_W-1:0]   lk_line;
  logic [ADC_BITS-1:0] lk_sample;
  logic [SLOT_W-1:0]   j;
  logic [KC_W-1:0]     kc;
  logic [ADC_BITS-1:0] nom_j, tol_j, lower, upper;
  logic [CODE_W-1:0]   code_j;
  logic                cut_lo, cut_hi;
  logic                have_pend;
  logic [CODE_W-1:0]   pend_code;
  logic [SLOT_W-1:0]   pend_slot;

  // scan evaluation of the entry in rd_data (slot kc-1)
  logic [SLOT_W-1:0]   ev_idx;
  logic                ev_near, ev_above;
  logic [ADC_BITS-1:0] ev_d, ev_half, ev_cand;
  logic [ADC_BITS:0]   ev_sum, ev_dp1;
  logic                hit;
  logic                j_last;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign wr_en  = accept && (request.req_type == REQ_WRITE)
                  && (int'(request.key_slot) < KEY_SLOTS);
  assign j_last = (j == SLOT_W'(KEY_SLOTS - 1));

  always_comb begin
    wr_entry.line      = request.line_id;
    wr_entry.nominal   = request.ad_value;
    wr_entry.tolerance = request.half_width;
    wr_entry.code      = request.key_code;
  end

  always_comb begin
    if (state == S_K_SCAN) begin
      rd_addr = kc[SLOT_W-1:0];
    end else begin
      rd_addr = j;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[request.key_slot[SLOT_W-1:0]] <= wr_entry;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= '0;
    end else if (wr_en) begin
      key_valid[request.key_slot[SLOT_W-1:0]] <= request.entry_valid;
    end
  end

  always_comb begin
    ev_idx   = SLOT_W'(kc - KC_W'(1));
    ev_above = (nom_j > rd_data.nominal);
    ev_d     = ev_above ? (nom_j - rd_data.nominal) : (rd_data.nominal - nom_j);
    ev_sum   = {1'b0, tol_j} + {1'b0, rd_data.tolerance};
    ev_dp1   = {1'b0, ev_d} + (ADC_BITS + 1)'(1);
    ev_half  = ev_dp1[ADC_BITS:1];
    ev_cand  = ev_above ? (ev_half - ADC_BITS'(1)) : ev_half;
    ev_near  = (kc != '0) && key_valid[ev_idx] && (rd_data.line == lk_line)
               && (ev_d != '0) && ({1'b0, ev_d} <= ev_sum);
    hit      = (({1'b0, lk_sample} + {1'b0, lower}) >= {1'b0, nom_j})
               && ({1'b0, lk_sample} <= ({1'b0, nom_j} + {1'b0, upper}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_strobe <= 1'b0;
      have_pend     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          result_strobe <= 1'b0;
          if (accept && request.req_type == REQ_LOOKUP) begin
            lk_line   <= request.line_id;
            lk_sample <= request.ad_value;
            j         <= '0;
            have_pend <= 1'b0;
            state     <= S_J_REQ;
          end
        end
        S_J_REQ: begin
          result_strobe <= 1'b0;
          if (key_valid[j]) begin
            state <= S_J_LOAD;
          end else if (j_last) begin
            state <= S_DONE;
          end else begin
            j <= j + SLOT_W'(1);
          end
        end
        S_J_LOAD: begin
          result_strobe <= 1'b0;
          if (rd_data.line != lk_line) begin
            if (j_last) begin
              state <= S_DONE;
            end else begin
              j     <= j + SLOT_W'(1);
              state <= S_J_REQ;
            end
          end else begin
            nom_j  <= rd_data.nominal;
            tol_j  <= rd_data.tolerance;
            code_j <= rd_data.code;
            lower  <= rd_data.tolerance;
            upper  <= rd_data.tolerance;
            cut_lo <= 1'b0;
            cut_hi <= 1'b0;
            kc     <= '0;
            state  <= S_K_SCAN;
          end
        end
        S_K_SCAN: begin
          result_strobe <= 1'b0;
          // nearest neighbor on each side sets the cut
          if (ev_near) begin
            if (ev_above) begin
              if (!cut_lo || ev_cand < lower) begin
                lower  <= ev_cand;
                cut_lo <= 1'b1;
              end
            end else begin
              if (!cut_hi || ev_cand < upper) begin
                upper  <= ev_cand;
                cut_hi <= 1'b1;
              end
            end
          end
          if (kc == KC_W'(KEY_SLOTS)) begin
            state <= S_TEST;
          end else begin
            kc <= kc + KC_W'(1);
          end
        end
        S_TEST: begin
          result_strobe <= hit && have_pend;
          if (hit) begin
            // a newer hit means the held one is not the last
            if (have_pend) begin
              result.found_code <= pend_code;
              result.found_slot <= 4'(pend_slot);
              result.found      <= 1'b1;
              result.last       <= 1'b0;
            end
            have_pend <= 1'b1;
            pend_code <= code_j;
            pend_slot <= j;
          end
          if (j_last) begin
            state <= S_DONE;
          end else begin
            j     <= j + SLOT_W'(1);
            state <= S_J_REQ;
          end
        end
        S_DONE: begin
          result_strobe <= 1'b1;
          result.last   <= 1'b1;
          if (have_pend) begin
            result.found_code <= pend_code;
            result.found_slot <= 4'(pend_slot);
            result.found      <= 1'b1;
          end else begin
            result.found_code <= '0;
            result.found_slot <= '0;
            result.found      <= 1'b0;
          end
          have_pend <= 1'b0;
          state     <= S_IDLE;
        end
        default: begin
          result_strobe <= 1'b0;
          state         <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
